// ===== sv/fpfl_pkg.sv =====
// Shared constants, codes and controller/datapath bundles for the slot pool allocator.
`default_nettype none

package fpfl_pkg;

   localparam int DEFAULT_MAX_UNITS = 64;
   localparam int DEFAULT_IDX_W     = $clog2(DEFAULT_MAX_UNITS);
   localparam int DEFAULT_CNT_W     = $clog2(DEFAULT_MAX_UNITS + 1);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_NOT_ALLOC = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       alloc_claim;
      logic       alloc_commit;
      logic       free_unlink;
      logic       free_link;
      logic       status_we;
      logic [1:0] status_code;
      logic       load_rsp;
   } fpfl_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic pool_empty;
      logic out_of_range;
      logic slot_used;
      logic rsp_busy;
   } fpfl_stat_type;

endpackage

`default_nettype wire

// ===== sv/fpfl_if.sv =====
// Valid/ready channel interfaces for allocator requests and responses.
`default_nettype none

interface fpfl_req_if import fpfl_pkg::*; #(
   parameter int IDX_W = DEFAULT_IDX_W
);
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [IDX_W-1:0] unit_index;

   modport source (output valid, req_type, unit_index, input ready);
   modport sink   (input valid, req_type, unit_index, output ready);
endinterface

interface fpfl_rsp_if import fpfl_pkg::*; #(
   parameter int IDX_W = DEFAULT_IDX_W,
   parameter int CNT_W = DEFAULT_CNT_W
);
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] granted_index;
   logic [1:0]       status;
   logic [CNT_W-1:0] free_slots;

   modport source (output valid, granted_index, status, free_slots, input ready);
   modport sink   (input valid, granted_index, status, free_slots, output ready);
endinterface

`default_nettype wire

// ===== sv/fpfl_ctrl.sv =====
// Request sequencer that steps the allocator datapath through each word.
`default_nettype none

module fpfl_ctrl import fpfl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire fpfl_stat_type st,
   output      fpfl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_UNLINK = 3'd3;
   localparam logic [2:0] ST_LINK   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (st.is_alloc) begin
               if (st.pool_empty) begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = STATUS_EMPTY;
                  state_in        = ST_DONE;
               end else begin
                  cmd.alloc_claim = 1'b1;
                  state_in        = ST_EXEC;
               end
            end else if (st.out_of_range) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = STATUS_RANGE;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_UNLINK;
            end
         end
         ST_EXEC: begin
            cmd.alloc_commit = 1'b1;
            state_in         = ST_DONE;
         end
         ST_UNLINK: begin
            if (st.slot_used) begin
               cmd.free_unlink = 1'b1;
               state_in        = ST_LINK;
            end else begin
               cmd.status_we   = 1'b1;
               cmd.status_code = STATUS_NOT_ALLOC;
               state_in        = ST_DONE;
            end
         end
         ST_LINK: begin
            cmd.free_link = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!st.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/fpfl_dp.sv =====
// Link memories, list heads, counters and response register of the allocator.
`default_nettype none

module fpfl_dp import fpfl_pkg::*; #(
   parameter int MAX_UNITS = DEFAULT_MAX_UNITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [$clog2(MAX_UNITS+1)-1:0]     csr_wr_data,
   input  wire logic                               req_type,
   input  wire logic [$clog2(MAX_UNITS)-1:0]       unit_index,
   input  wire fpfl_cmd_type                       cmd,
   output      fpfl_stat_type                      st,
   input  wire logic                               rsp_ready,
   output      logic                               rsp_valid,
   output      logic [$clog2(MAX_UNITS)-1:0]       rsp_granted_index,
   output      logic [1:0]                         rsp_status,
   output      logic [$clog2(MAX_UNITS+1)-1:0]     rsp_free_slots
);

   localparam int IDX_W = $clog2(MAX_UNITS);
   localparam int CNT_W = $clog2(MAX_UNITS + 1);
   localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_UNITS);
   localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

   logic [CNT_W-1:0] next_mem [MAX_UNITS];
   logic [CNT_W-1:0] prev_mem [MAX_UNITS];
   logic             used_mem [MAX_UNITS];

   logic [CNT_W-1:0] units_ff,      units_in;
   logic [CNT_W-1:0] free_head_ff,  free_head_in;
   logic [CNT_W-1:0] alloc_head_ff, alloc_head_in;
   logic [CNT_W-1:0] total_ff,      total_in;
   logic [CNT_W-1:0] fresh_ff,      fresh_in;
   logic             rsp_valid_ff,  rsp_valid_in;

   logic             type_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] next_rd_ff;
   logic [CNT_W-1:0] prev_rd_ff;
   logic             used_rd_ff;
   logic [IDX_W-1:0] granted_ff;
   logic [1:0]       status_ff;
   logic [IDX_W-1:0] rsp_granted_ff;
   logic [1:0]       rsp_status_ff;
   logic [CNT_W-1:0] rsp_free_ff;

   logic             head_valid;
   logic             alloc_valid;
   logic             head_fresh;
   logic             prev_valid;
   logic             next_valid;
   logic [CNT_W-1:0] idx_link;
   logic [CNT_W-1:0] fresh_next;
   logic [CNT_W-1:0] new_head;
   logic [CNT_W-1:0] csr_units;
   logic [IDX_W-1:0] rd_next_addr;

   logic             next_we;
   logic [IDX_W-1:0] next_wa;
   logic [CNT_W-1:0] next_wd;
   logic             prev_we;
   logic [IDX_W-1:0] prev_wa;
   logic [CNT_W-1:0] prev_wd;
   logic             used_we;
   logic [IDX_W-1:0] used_wa;
   logic             used_wd;

   assign idx_link    = CNT_W'(idx_ff);
   assign head_valid  = (free_head_ff != NULL_LINK);
   assign alloc_valid = (alloc_head_ff != NULL_LINK);
   assign prev_valid  = (prev_rd_ff != NULL_LINK);
   assign next_valid  = (next_rd_ff != NULL_LINK);
   // units below the fresh mark still sit in the untouched descending tail
   assign head_fresh  = (free_head_ff < fresh_ff);
   assign fresh_next  = (free_head_ff == '0) ? NULL_LINK : (free_head_ff - ONE);
   assign new_head    = head_fresh ? fresh_next : next_rd_ff;
   assign csr_units   = (csr_wr_data == '0)      ? ONE :
                        (csr_wr_data > NULL_LINK) ? NULL_LINK : csr_wr_data;
   assign rd_next_addr = (type_ff == REQ_ALLOC) ? free_head_ff[IDX_W-1:0] : idx_ff;

   always_comb begin
      st.is_alloc     = (type_ff == REQ_ALLOC);
      st.pool_empty   = !head_valid;
      st.out_of_range = (idx_link >= units_ff);
      st.slot_used    = (idx_link >= fresh_ff) && used_rd_ff;
      st.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      next_we = 1'b0;
      next_wa = free_head_ff[IDX_W-1:0];
      next_wd = alloc_head_ff;
      prev_we = 1'b0;
      prev_wa = free_head_ff[IDX_W-1:0];
      prev_wd = NULL_LINK;
      used_we = 1'b0;
      used_wa = free_head_ff[IDX_W-1:0];
      used_wd = 1'b1;
      if (cmd.alloc_claim) begin
         prev_we = alloc_valid;
         prev_wa = alloc_head_ff[IDX_W-1:0];
         prev_wd = free_head_ff;
         used_we = 1'b1;
      end
      if (cmd.alloc_commit) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end
      if (cmd.free_unlink) begin
         next_we = prev_valid;
         next_wa = prev_rd_ff[IDX_W-1:0];
         next_wd = next_rd_ff;
         prev_we = next_valid;
         prev_wa = next_rd_ff[IDX_W-1:0];
         prev_wd = prev_rd_ff;
         used_we = 1'b1;
         used_wa = idx_ff;
         used_wd = 1'b0;
      end
      if (cmd.free_link) begin
         next_we = 1'b1;
         next_wa = idx_ff;
         next_wd = free_head_ff;
      end
   end

   always_comb begin
      units_in      = units_ff;
      free_head_in  = free_head_ff;
      alloc_head_in = alloc_head_ff;
      total_in      = total_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (csr_wr_en) begin
         units_in      = csr_units;
         free_head_in  = csr_units - ONE;
         alloc_head_in = NULL_LINK;
         total_in      = csr_units;
         fresh_in      = csr_units;
      end
      if (cmd.alloc_commit) begin
         free_head_in  = new_head;
         alloc_head_in = free_head_ff;
         total_in      = total_ff - ONE;
         if (head_fresh) begin
            fresh_in = fresh_ff - ONE;
         end
      end
      if (cmd.free_unlink && !prev_valid) begin
         alloc_head_in = next_rd_ff;
      end
      if (cmd.free_link) begin
         free_head_in = idx_link;
         total_in     = total_ff + ONE;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff      <= NULL_LINK;
         free_head_ff  <= NULL_LINK - ONE;
         alloc_head_ff <= NULL_LINK;
         total_ff      <= NULL_LINK;
         fresh_ff      <= NULL_LINK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         units_ff      <= units_in;
         free_head_ff  <= free_head_in;
         alloc_head_ff <= alloc_head_in;
         total_ff      <= total_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff    <= req_type;
         idx_ff     <= unit_index;
         granted_ff <= '0;
         status_ff  <= STATUS_OK;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.alloc_commit) begin
         granted_ff <= free_head_ff[IDX_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_granted_ff <= granted_ff;
         rsp_status_ff  <= status_ff;
         rsp_free_ff    <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      next_rd_ff <= next_mem[rd_next_addr];
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
   end

   always_ff @(posedge clock) begin
      prev_rd_ff <= prev_mem[idx_ff];
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   always_ff @(posedge clock) begin
      used_rd_ff <= used_mem[idx_ff];
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_slots    = rsp_free_ff;

endmodule

`default_nettype wire

// ===== sv/fixed_pool_free_list_allocator.sv =====
// Top level of the fixed-size slot pool allocator with free and allocated lists.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid/ready        req_type, unit_index
//   rsp_ch    out   valid/ready        granted_index, status, free_slots
//   csr_*     in    csr_wr_en          csr_wr_data (unit count)
//
// From acceptance a request steps through evaluation to done: allocate claims, commits;
// free unlinks, links; an empty pool or bad index goes to done; an unallocated slot stops
// after the unlink check. Done loads the response word once rsp_ch is not stalled.
// One request is in flight at a time; the response register holds a finished word
// while rsp_ch stalls, and the next request may be accepted meanwhile.
// Reset restores a full pool with no clearing pass; a fresh mark tracks never-used slots.
`default_nettype none

module fixed_pool_free_list_allocator import fpfl_pkg::*; #(
   parameter int MAX_UNITS = DEFAULT_MAX_UNITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [$clog2(MAX_UNITS+1)-1:0] csr_wr_data,
   fpfl_req_if.sink                            req_ch,
   fpfl_rsp_if.source                          rsp_ch
);

   localparam int CNT_W = $clog2(MAX_UNITS + 1);

   fpfl_cmd_type  cmd;
   fpfl_stat_type st;
   logic          req_ready;

   fpfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   fpfl_dp #(
      .MAX_UNITS (MAX_UNITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_type          (req_ch.req_type),
      .unit_index        (req_ch.unit_index),
      .cmd               (cmd),
      .st                (st),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_granted_index (rsp_ch.granted_index),
      .rsp_status        (rsp_ch.status),
      .rsp_free_slots    (rsp_ch.free_slots)
   );

   assign req_ch.ready = req_ready;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_single_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.alloc_claim, cmd.alloc_commit, cmd.free_unlink, cmd.free_link}))
      else $error("more than one list update in a cycle");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |-> (rsp_ch.granted_index == '0))
      else $error("nonzero grant on a failed request");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.free_slots <= CNT_W'(MAX_UNITS)))
      else $error("free slot count above pool size");

endmodule

`default_nettype wire
